@@ design/open_addressing_hash_table_defines.svh @@
// Assertion macros shared by the hash table checker.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OAHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OAHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table check failed: next-cycle rule");

`endif

@@ design/oaht_pkg.sv @@
// Types and constants of the open addressing hash table.
package oaht_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int KEY_BITS_DEF = 64;
	localparam int DATA_BITS_DEF = 64;

	localparam int HASH_BITS = 32;
	localparam int KEY_PORT_BITS = 64;
	localparam int DATA_PORT_BITS = 64;

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_SET = 2'd1,
		OP_DEL = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_HIT = 2'd0,
		ST_NEW = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_USED = 2'd1,
		KIND_TOMB = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_START,
		S_PROBE
	} state_t;

endpackage

@@ design/oaht_ram.sv @@
// Simple dual-port synchronous RAM with one write and one registered read port.
module oaht_ram #(
	parameter int WIDTH = 130,
	parameter int DEPTH = oaht_pkg::SLOTS_DEF,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/oaht_slot_mod.sv @@
// Reduces the 32-bit hash to a start slot, hash modulo the slot count.
module oaht_slot_mod #(
	parameter int SLOTS = oaht_pkg::SLOTS_DEF,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [oaht_pkg::HASH_BITS-1:0] hash,
	output logic                           ready,
	output logic [IDX_W-1:0]               idx
);

	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam int PROD_W = 2 * oaht_pkg::HASH_BITS;
	// The reciprocal floor(2^32 / SLOTS) gives a quotient that is low by at most one.
	localparam logic [oaht_pkg::HASH_BITS-1:0] RECIP =
		oaht_pkg::HASH_BITS'((64'd1 << oaht_pkg::HASH_BITS) / 64'(SLOTS));

	logic [oaht_pkg::HASH_BITS-1:0] hash_q;
	logic [oaht_pkg::HASH_BITS-1:0] quo_q;
	logic [IDX_W-1:0]               rem_q;
	logic                           step1_q;
	logic                           step2_q;
	logic                           ready_q;
	logic [PROD_W-1:0]              prod;
	logic [oaht_pkg::HASH_BITS-1:0] back;
	logic [oaht_pkg::HASH_BITS-1:0] diff;
	logic [IDX_W:0]                 trial;

	// The step1_q stage estimates the quotient, step2_q takes the remainder, which
	// lies below twice the slot count and needs one conditional subtraction.
	assign prod = PROD_W'(hash_q) * PROD_W'(RECIP);
	assign back = quo_q * oaht_pkg::HASH_BITS'(SLOTS);
	assign diff = hash_q - back;
	assign trial = diff[IDX_W:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step1_q <= 1'b0;
			step2_q <= 1'b0;
			ready_q <= 1'b1;
		end else begin
			step1_q <= go && !POW2;
			step2_q <= step1_q;
			if (go) begin
				ready_q <= POW2;
			end else if (step2_q) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hash_q <= hash;
			rem_q <= hash[IDX_W-1:0];
		end
		if (step1_q) begin
			quo_q <= prod[PROD_W-1 -: oaht_pkg::HASH_BITS];
		end
		if (step2_q) begin
			if (trial >= (IDX_W + 1)'(SLOTS)) begin
				rem_q <= IDX_W'(trial - (IDX_W + 1)'(SLOTS));
			end else begin
				rem_q <= trial[IDX_W-1:0];
			end
		end
	end

	assign ready = ready_q;
	assign idx = rem_q;

endmodule

@@ design/open_addressing_hash_table.sv @@
// Top level of the open addressing hash table with linear probing and tombstones.
//
// The table holds SLOTS key/value entries in one synchronous RAM, each entry
// tagged empty, occupied or tombstone. An item is taken when start is high
// and busy is low; its result appears on status and data_out for exactly
// one cycle with done high, and the receiver cannot stall it. For a get, set
// or delete, done rises once the probe has checked the slots it visits
// (one RAM read per cycle, the next read issued while the previous entry is
// checked); with a slot count that is not a power of two the start slot
// first comes from a reciprocal multiplication. The next item can be taken
// in the cycle that done is shown. A clear sweeps all SLOTS entries, one per
// cycle, and reports when the sweep ends. After reset the same sweep runs
// with busy high and no result. A new key that would take a fresh empty
// slot once three quarters of the slots are used (tombstones count) is
// refused with status full; reusing a tombstone is never refused.
module open_addressing_hash_table #(
	parameter int SLOTS = oaht_pkg::SLOTS_DEF,
	parameter int KEY_BITS = oaht_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = oaht_pkg::DATA_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic [oaht_pkg::KEY_PORT_BITS-1:0]  key,
	input  logic [oaht_pkg::HASH_BITS-1:0]      key_hash,
	input  logic [oaht_pkg::DATA_PORT_BITS-1:0] data_in,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [oaht_pkg::DATA_PORT_BITS-1:0] data_out
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ENTRY_W = 2 + KEY_BITS + DATA_BITS;
	// A fresh slot is refused once used_q reaches this, i.e. 4*(used+1) > 3*SLOTS.
	localparam int FULL_AT = (3 * SLOTS) / 4;

	oaht_pkg::state_t state_q, state_d;

	logic                  accept;
	logic [IDX_W-1:0]      sweep_q;
	logic                  report_q;
	logic [CNT_W-1:0]      used_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      n_q;
	logic                  tomb_seen_q;
	logic [IDX_W-1:0]      tomb_q;
	oaht_pkg::op_t         op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [DATA_BITS-1:0]  data_q;
	logic                  done_q;
	oaht_pkg::status_t     status_q;
	logic [DATA_BITS-1:0]  data_out_q;

	logic                  mod_ready;
	logic [IDX_W-1:0]      mod_idx;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;

	oaht_pkg::kind_t       rd_kind;
	logic [KEY_BITS-1:0]   rd_key;
	logic [DATA_BITS-1:0]  rd_data;
	logic [IDX_W-1:0]      next_idx;
	logic                  last_probe;
	logic                  sweep_last;

	// Probe evaluation of the entry read for cur_q.
	logic                  found;
	logic                  at_empty;
	logic                  is_tomb;
	logic                  has_target;
	logic                  target_empty;
	logic [IDX_W-1:0]      target;
	logic                  fin;
	logic                  used_inc;
	oaht_pkg::status_t     res_status;
	logic [DATA_BITS-1:0]  res_data;

	assign accept = start && (state_q == oaht_pkg::S_IDLE);
	assign busy = (state_q != oaht_pkg::S_IDLE);

	oaht_slot_mod #(
		.SLOTS(SLOTS)
	) u_slot_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (accept),
		.hash  (key_hash),
		.ready (mod_ready),
		.idx   (mod_idx)
	);

	oaht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Entry layout in the RAM: kind on top, then key, then value.
	assign rd_kind = oaht_pkg::kind_t'(ram_rdata[ENTRY_W-1 -: 2]);
	assign rd_key = ram_rdata[DATA_BITS +: KEY_BITS];
	assign rd_data = ram_rdata[DATA_BITS-1:0];

	assign next_idx = (cur_q == IDX_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
	assign last_probe = (n_q == IDX_W'(SLOTS - 1));
	assign sweep_last = (sweep_q == IDX_W'(SLOTS - 1));

	// Classify the slot under the probe. A kind code that is never written is
	// treated like an empty slot, so the probe always terminates there.
	always_comb begin
		found = 1'b0;
		at_empty = 1'b0;
		is_tomb = 1'b0;
		case (rd_kind)
			oaht_pkg::KIND_USED: found = (rd_key == key_q);
			oaht_pkg::KIND_TOMB: is_tomb = 1'b1;
			default: at_empty = 1'b1;
		endcase
	end

	// The set target is the first tombstone passed, else the empty slot that
	// ended the probe. If the probe runs out of slots, only a tombstone counts.
	always_comb begin
		if (tomb_seen_q) begin
			has_target = at_empty || last_probe;
			target = tomb_q;
			target_empty = 1'b0;
		end else if (at_empty) begin
			has_target = 1'b1;
			target = cur_q;
			target_empty = 1'b1;
		end else begin
			has_target = is_tomb && last_probe;
			target = cur_q;
			target_empty = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			oaht_pkg::S_SWEEP: begin
				if (sweep_last) begin
					state_d = oaht_pkg::S_IDLE;
				end
			end
			oaht_pkg::S_IDLE: begin
				if (accept) begin
					if (oaht_pkg::op_t'(op) == oaht_pkg::OP_CLEAR) begin
						state_d = oaht_pkg::S_SWEEP;
					end else begin
						state_d = oaht_pkg::S_START;
					end
				end
			end
			oaht_pkg::S_START: begin
				if (mod_ready) begin
					state_d = oaht_pkg::S_PROBE;
				end
			end
			oaht_pkg::S_PROBE: begin
				if (fin) begin
					state_d = oaht_pkg::S_IDLE;
				end
			end
			default: state_d = oaht_pkg::S_SWEEP;
		endcase
	end

	// RAM access and the result of the probe. Each write of a get, set or delete
	// happens in its deciding cycle, after its last read, so no read can see a stale entry.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '0;
		ram_raddr = next_idx;
		fin = 1'b0;
		used_inc = 1'b0;
		res_status = oaht_pkg::ST_HIT;
		res_data = '0;
		case (state_q)
			oaht_pkg::S_SWEEP: begin
				ram_we = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = {oaht_pkg::KIND_EMPTY, {(ENTRY_W - 2){1'b0}}};
			end
			oaht_pkg::S_START: begin
				ram_raddr = mod_idx;
			end
			oaht_pkg::S_PROBE: begin
				fin = found || at_empty || last_probe;
				if (fin) begin
					case (op_q)
						oaht_pkg::OP_GET: begin
							if (found) begin
								res_data = rd_data;
							end else begin
								res_status = oaht_pkg::ST_MISS;
							end
						end
						oaht_pkg::OP_DEL: begin
							if (found) begin
								ram_we = 1'b1;
								ram_wdata = {oaht_pkg::KIND_TOMB, rd_key, rd_data};
							end else begin
								res_status = oaht_pkg::ST_MISS;
							end
						end
						oaht_pkg::OP_SET: begin
							if (found) begin
								ram_we = 1'b1;
								ram_wdata = {oaht_pkg::KIND_USED, key_q, data_q};
							end else if (!has_target) begin
								res_status = oaht_pkg::ST_FULL;
							end else if (target_empty && (used_q >= CNT_W'(FULL_AT))) begin
								res_status = oaht_pkg::ST_FULL;
							end else begin
								ram_we = 1'b1;
								ram_waddr = target;
								ram_wdata = {oaht_pkg::KIND_USED, key_q, data_q};
								used_inc = target_empty;
								res_status = oaht_pkg::ST_NEW;
							end
						end
						default: res_status = oaht_pkg::ST_HIT;
					endcase
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::S_SWEEP;
			sweep_q <= '0;
			report_q <= 1'b0;
			used_q <= '0;
			n_q <= '0;
			tomb_seen_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			case (state_q)
				oaht_pkg::S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						done_q <= report_q;
						report_q <= 1'b0;
					end
				end
				oaht_pkg::S_IDLE: begin
					if (accept) begin
						sweep_q <= '0;
						n_q <= '0;
						tomb_seen_q <= 1'b0;
						if (oaht_pkg::op_t'(op) == oaht_pkg::OP_CLEAR) begin
							report_q <= 1'b1;
							used_q <= '0;
						end
					end
				end
				oaht_pkg::S_PROBE: begin
					if (fin) begin
						done_q <= 1'b1;
						if (used_inc) begin
							used_q <= used_q + 1'b1;
						end
					end else begin
						n_q <= n_q + 1'b1;
						if (is_tomb) begin
							tomb_seen_q <= 1'b1;
						end
					end
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	// Item operands, probe position and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= oaht_pkg::op_t'(op);
			key_q <= key[KEY_BITS-1:0];
			data_q <= data_in[DATA_BITS-1:0];
		end
		if (state_q == oaht_pkg::S_START && mod_ready) begin
			cur_q <= mod_idx;
		end
		if (state_q == oaht_pkg::S_PROBE && !fin) begin
			cur_q <= next_idx;
			if (is_tomb && !tomb_seen_q) begin
				tomb_q <= cur_q;
			end
		end
		if (state_q == oaht_pkg::S_PROBE && fin) begin
			status_q <= res_status;
			data_out_q <= res_data;
		end else if (state_q == oaht_pkg::S_SWEEP) begin
			status_q <= oaht_pkg::ST_HIT;
			data_out_q <= '0;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign data_out = oaht_pkg::DATA_PORT_BITS'(data_out_q);

endmodule

@@ design/oaht_checker.sv @@
// Port-level checker for the hash table, bound to the top level.
`include "open_addressing_hash_table_defines.svh"

module oaht_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic [1:0]                          status,
	input logic [oaht_pkg::DATA_PORT_BITS-1:0] data_out
);

	// A result is only shown once the item has finished, so the block is free.
	`OAHT_ASSERT_NOW(a_done_not_busy, done, !busy)

	// Every accepted item occupies the block for at least the next cycle.
	`OAHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// Only a hit can carry a nonzero value.
	`OAHT_ASSERT_NOW(a_data_on_hit, done && (data_out != '0), status == oaht_pkg::ST_HIT)

	// Each item yields a single result pulse.
	`OAHT_ASSERT_NEXT(a_single_result, done, !done)

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);
